FILE: rtl/core/ewma_prr_pkg.sv
// Package for the pair regression residual block: command codes, widths
// and fixed-point constants. No dependencies.
package ewma_prr_pkg;

   // Event commands carried on the input tuser bits
   typedef enum logic [1:0] {
      CMD_PRICE  = 2'd0,
      CMD_INTR   = 2'd1,
      CMD_RESUME = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   localparam int PRICE_W  = 24;
   localparam int CUR_W    = 28;   // latest prices, signed Q.8
   localparam int TWICE_W  = 26;
   localparam int AVG_P_W  = 44;   // price averages, Q.24
   localparam int AVG_X_W  = 64;   // product averages, Q.16
   localparam int IND_W    = 41;   // indicator, Q32.8
   localparam int MA_W     = 54;   // multiplier full-width operand
   localparam int MB_W     = 17;   // multiplier chunk operand
   localparam int MBF_W    = 51;   // chunked operand, three chunks
   localparam int ACC_W    = 96;   // product accumulator / dividend
   localparam int DIVD_W   = 52;   // divisor and remainder width
   localparam int QUOT_W   = 61;   // quotient, holds the cap itself

   localparam logic [63:0]         ONE_Q16  = 64'd65536;
   localparam logic [QUOT_W:0]     QUOT_CAP = {2'b01, {(QUOT_W - 1){1'b0}}};
   localparam logic [15:0]         DECAY_RST = 16'd62259;
   localparam logic signed [47:0]  IND_MAX  = 48'sh00FF_FFFF_FFFF;
   localparam logic signed [47:0]  IND_MIN  = -48'sh0100_0000_0000;

endpackage

FILE: rtl/core/ewma_pair_regression_residual.sv
// Pair regression residual: four exponential averages and a residual
// built on one shared 54x17 multiplier and a one-bit-per-cycle divider.
// Depends on ewma_prr_pkg.
//
// Usage
//   req_* : one event word per handshake. tuser = {is_dependent, command};
//           tdata = {7'b0, both_ready, price}.
//   rsp_* : one indicator word (signed Q32.8 in tdata[40:0]) for events that
//           produce a result; resume, dependent interrupt and the unused
//           command produce none.
//   csr_* : write of the decay factor (Q0.16), taken any cycle; write only
//           while the block is idle.
// Sequencing
//   req_tready is high only while the sequencer is idle, so a new word is
//   accepted only once the last one is through. A tracked price update
//   runs two 2-chunk products, four 1-chunk average updates, a 3-chunk
//   product and a 96-step restoring division, which dominates. With the
//   square average at most 1.0 the division is skipped. Seeding runs only
//   the two 2-chunk products.
// Reset clears the averages, prices, flags and the decay factor to 62259.
// A stalled rsp side holds the finished word in the output register; the
// sequencer waits in its final state until that register frees.
module ewma_pair_regression_residual (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [23:0] price, [24] both_ready
   input  logic [2:0]  req_tuser,   // [1:0] command, [2] is_dependent
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [40:0] indicator
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);
   import ewma_prr_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_M_CROSS, ST_W_CROSS, ST_M_SQUARE, ST_W_SQUARE,
      ST_M_EWMA, ST_W_EWMA, ST_CHECK, ST_M_RES, ST_DIV, ST_FIN, ST_DONE
   } state_type;

   state_type                  state_ff;
   logic [15:0]                decay_ff;
   logic                       ready_ff, intr_ff, seeding_ff, emit_ff;
   logic [CUR_W-1:0]           cur_dep_ff;
   logic signed [CUR_W-1:0]    cur_ind_ff;
   logic [TWICE_W-1:0]         twice_ff;
   logic signed [AVG_P_W-1:0]  avg_dep_ff, avg_ind_ff;
   logic signed [AVG_X_W-1:0]  avg_cross_ff, avg_sq_ff, cross_x_ff, sq_x_ff;
   logic signed [IND_W-1:0]    last_ff;
   logic [1:0]                 k_ff, ew_ff;
   logic [ACC_W-1:0]           acc_ff, acc_in;
   logic [DIVD_W-1:0]          rem_ff;
   logic [QUOT_W-1:0]          q_ff;
   logic                       sat_ff, neg_ff;
   logic [6:0]                 cnt_ff;
   logic                       rsp_valid_ff;
   logic [47:0]                rsp_data_ff;

   // input fields
   logic [1:0]          in_cmd;
   logic                in_dep, in_both;
   logic [PRICE_W-1:0]  in_price;
   assign in_cmd   = req_tuser[1:0];
   assign in_dep   = req_tuser[2];
   assign in_price = req_tdata[23:0];
   assign in_both  = req_tdata[24];

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // signed 64-bit views of samples and averages
   logic signed [63:0] x_dep, x_ind, a_dep, a_ind, ind64;
   assign x_dep = $signed({20'd0, cur_dep_ff, 16'd0});
   assign x_ind = $signed({{20{cur_ind_ff[CUR_W-1]}}, cur_ind_ff, 16'd0});
   assign a_dep = $signed({{20{avg_dep_ff[AVG_P_W-1]}}, avg_dep_ff});
   assign a_ind = $signed({{20{avg_ind_ff[AVG_P_W-1]}}, avg_ind_ff});
   assign ind64 = $signed({{(64 - CUR_W){cur_ind_ff[CUR_W-1]}}, cur_ind_ff});

   logic [63:0] ind_mag;
   assign ind_mag = ind64[63] ? 64'(-ind64) : 64'(ind64);

   // average update operands, selected by the average index
   logic signed [63:0] ew_x, ew_a, ew_diff;
   logic [63:0]        ew_mag;
   always_comb begin
      case (ew_ff)
         2'd0: begin
            ew_x = x_dep;      ew_a = a_dep;
         end
         2'd1: begin
            ew_x = x_ind;      ew_a = a_ind;
         end
         2'd2: begin
            ew_x = cross_x_ff; ew_a = avg_cross_ff;
         end
         default: begin
            ew_x = sq_x_ff;    ew_a = avg_sq_ff;
         end
      endcase
   end
   assign ew_diff = ew_x - ew_a;
   assign ew_mag  = ew_diff[63] ? 64'(-ew_diff) : 64'(ew_diff);

   // residual operands
   logic signed [63:0] dx, dy;
   logic [63:0]        dx_mag, cross_mag;
   assign dx        = x_ind - a_ind;
   assign dy        = x_dep - a_dep;
   assign dx_mag    = dx[63] ? 64'(-dx) : 64'(dx);
   assign cross_mag = avg_cross_ff[63] ? 64'(-avg_cross_ff) : 64'(avg_cross_ff);

   logic [16:0] w_val;
   assign w_val = 17'h10000 - {1'b0, decay_ff};

   // shared multiplier: A times one 17-bit chunk of B, accumulated
   logic [MA_W-1:0]      mul_a;
   logic [MBF_W-1:0]     mul_b;
   logic [1:0]           k_last;
   logic [MB_W-1:0]      b_chunk;
   logic [MA_W+MB_W-1:0] part;
   logic [ACC_W-1:0]     part_sh;
   always_comb begin
      case (state_ff)
         ST_M_CROSS: begin
            mul_a = MA_W'(ind_mag[25:0]);
            mul_b = MBF_W'(cur_dep_ff);
            k_last = 2'd1;
         end
         ST_M_SQUARE: begin
            mul_a = MA_W'(ind_mag[25:0]);
            mul_b = MBF_W'(ind_mag[25:0]);
            k_last = 2'd1;
         end
         ST_M_EWMA: begin
            mul_a = ew_mag[MA_W-1:0];
            mul_b = MBF_W'(w_val);
            k_last = 2'd0;
         end
         default: begin
            mul_a = cross_mag[MA_W-1:0];
            mul_b = dx_mag[MBF_W-1:0];
            k_last = 2'd2;
         end
      endcase
      case (k_ff)
         2'd0:    b_chunk = mul_b[16:0];
         2'd1:    b_chunk = mul_b[33:17];
         default: b_chunk = mul_b[50:34];
      endcase
      part = mul_a * b_chunk;
      case (k_ff)
         2'd0:    part_sh = ACC_W'(part);
         2'd1:    part_sh = ACC_W'({part, 17'd0});
         default: part_sh = ACC_W'({part, 34'd0});
      endcase
      acc_in = ((k_ff == 2'd0) ? '0 : acc_ff) + part_sh;
   end

   // rounded average step
   logic [ACC_W-1:0]   acc_rnd;
   logic signed [63:0] ew_p, ew_new;
   assign acc_rnd = acc_ff + ACC_W'(32768);
   assign ew_p    = $signed(acc_rnd[79:16]);
   assign ew_new  = ew_diff[63] ? (ew_a - ew_p) : (ew_a + ew_p);

   // restoring division step
   logic [DIVD_W:0]   rem_sh;
   logic [DIVD_W:0]   dvs;
   logic              div_ge;
   logic [QUOT_W:0]   q_sh;
   assign rem_sh = {rem_ff, acc_ff[ACC_W-1]};
   assign dvs    = {1'b0, avg_sq_ff[DIVD_W-1:0]};
   assign div_ge = (rem_sh >= dvs);
   assign q_sh   = {q_ff, div_ge};

   // final rounding and saturation
   logic [QUOT_W-1:0]  q_fin;
   logic signed [63:0] q_sgn, v_sum;
   logic signed [47:0] r_val;
   logic signed [IND_W-1:0] r_sat;
   always_comb begin
      q_fin = sat_ff ? QUOT_CAP[QUOT_W-1:0] : q_ff;
      q_sgn = neg_ff ? -$signed({3'd0, q_fin}) : $signed({3'd0, q_fin});
      v_sum = q_sgn - dy + 64'sd32768;
      r_val = v_sum[63:16];
      if (r_val > IND_MAX)
         r_sat = IND_MAX[IND_W-1:0];
      else if (r_val < IND_MIN)
         r_sat = IND_MIN[IND_W-1:0];
      else
         r_sat = r_val[IND_W-1:0];
   end

   // sequencer and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         decay_ff     <= DECAY_RST;
         ready_ff     <= 1'b0;
         intr_ff      <= 1'b0;
         seeding_ff   <= 1'b0;
         emit_ff      <= 1'b0;
         cur_dep_ff   <= '0;
         cur_ind_ff   <= '0;
         twice_ff     <= '0;
         avg_dep_ff   <= '0;
         avg_ind_ff   <= '0;
         avg_cross_ff <= '0;
         avg_sq_ff    <= '0;
         last_ff      <= '0;
         k_ff         <= '0;
         ew_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            decay_ff <= csr_data;
         end
         // word taken and no new one loaded this cycle
         if (rsp_valid_ff && rsp_tready && !(state_ff == ST_DONE && emit_ff)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               k_ff <= '0;
               if (req_tvalid) begin
                  case (in_cmd)
                     CMD_INTR: begin
                        state_ff   <= ST_DONE;
                        seeding_ff <= 1'b1;
                        emit_ff    <= !in_dep;
                        if (!in_dep) begin
                           intr_ff <= 1'b1;
                           last_ff <= '0;
                        end
                     end
                     CMD_RESUME: begin
                        state_ff   <= in_dep ? ST_DONE : ST_M_CROSS;
                        seeding_ff <= 1'b1;
                        emit_ff    <= 1'b0;
                        if (!in_dep) begin
                           intr_ff <= 1'b0;
                        end
                     end
                     CMD_PRICE: begin
                        emit_ff <= 1'b1;
                        if (!ready_ff) begin
                           seeding_ff <= 1'b1;
                           if (in_dep)
                              cur_dep_ff <= CUR_W'(in_price);
                           else begin
                              cur_ind_ff <= $signed(CUR_W'(in_price));
                              twice_ff   <= {1'b0, in_price, 1'b0};
                           end
                           if (in_both) begin
                              ready_ff <= 1'b1;
                              state_ff <= ST_M_CROSS;
                           end else begin
                              state_ff <= ST_DONE;
                           end
                        end else begin
                           seeding_ff <= 1'b0;
                           if (in_dep)
                              cur_dep_ff <= CUR_W'(in_price);
                           else
                              cur_ind_ff <= $signed({2'd0, twice_ff})
                                          - $signed({4'd0, in_price});
                           state_ff <= ST_M_CROSS;
                        end
                     end
                     default: begin
                        state_ff   <= ST_DONE;
                        seeding_ff <= 1'b1;
                        emit_ff    <= 1'b0;
                     end
                  endcase
               end
            end
            ST_M_CROSS, ST_M_SQUARE, ST_M_EWMA, ST_M_RES: begin
               acc_ff <= acc_in;
               if (k_ff == k_last) begin
                  k_ff <= '0;
                  case (state_ff)
                     ST_M_CROSS:  state_ff <= ST_W_CROSS;
                     ST_M_SQUARE: state_ff <= ST_W_SQUARE;
                     ST_M_EWMA:   state_ff <= ST_W_EWMA;
                     default: begin
                        state_ff <= ST_DIV;
                        rem_ff   <= '0;
                        q_ff     <= '0;
                        sat_ff   <= 1'b0;
                        cnt_ff   <= '0;
                     end
                  endcase
               end else begin
                  k_ff <= k_ff + 2'd1;
               end
            end
            ST_W_CROSS: begin
               cross_x_ff <= ind64[63] ? -$signed(acc_ff[63:0]) : $signed(acc_ff[63:0]);
               state_ff   <= ST_M_SQUARE;
            end
            ST_W_SQUARE: begin
               sq_x_ff <= $signed(acc_ff[63:0]);
               ew_ff   <= '0;
               if (seeding_ff) begin
                  avg_dep_ff   <= x_dep[AVG_P_W-1:0];
                  avg_ind_ff   <= x_ind[AVG_P_W-1:0];
                  avg_cross_ff <= cross_x_ff;
                  avg_sq_ff    <= $signed(acc_ff[63:0]);
                  last_ff      <= '0;
                  state_ff     <= ST_DONE;
               end else begin
                  state_ff <= ST_M_EWMA;
               end
            end
            ST_W_EWMA: begin
               case (ew_ff)
                  2'd0:    avg_dep_ff   <= ew_new[AVG_P_W-1:0];
                  2'd1:    avg_ind_ff   <= ew_new[AVG_P_W-1:0];
                  2'd2:    avg_cross_ff <= ew_new;
                  default: avg_sq_ff    <= ew_new;
               endcase
               ew_ff    <= ew_ff + 2'd1;
               state_ff <= (ew_ff == 2'd3) ? ST_CHECK : ST_M_EWMA;
            end
            ST_CHECK: begin
               neg_ff <= avg_cross_ff[63] ^ dx[63];
               if (avg_sq_ff > $signed(ONE_Q16)) begin
                  state_ff <= ST_M_RES;
               end else begin
                  last_ff  <= '0;
                  state_ff <= ST_DONE;
               end
            end
            ST_DIV: begin
               acc_ff <= {acc_ff[ACC_W-2:0], 1'b0};
               rem_ff <= div_ge ? DIVD_W'(rem_sh - dvs) : rem_sh[DIVD_W-1:0];
               q_ff   <= q_sh[QUOT_W-1:0];
               if (q_sh > QUOT_CAP)
                  sat_ff <= 1'b1;
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'(ACC_W - 1))
                  state_ff <= ST_FIN;
            end
            ST_FIN: begin
               last_ff  <= r_sat;
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (!emit_ff) begin
                  state_ff <= ST_IDLE;
               end else if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {7'd0, last_ff};
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

FILE: tb/sv/tb_ewma_pair_regression_residual.sv
// Testbench for the pair regression residual block: directed table, then random
// tracked price streams under several decay settings, checked by a local predictor.
// Depends on ewma_prr_pkg and the ewma_pair_regression_residual RTL.
`timescale 1ns / 1ps

module tb_ewma_pair_regression_residual;
   import ewma_prr_pkg::*;

   localparam int     WATCHDOG_LIMIT = 5000;
   localparam int     SETTLE_CYCLES  = 200;
   localparam int     RANDOM_WORDS   = 680;
   localparam longint Q16            = 65536;
   localparam longint QUO_CAP        = 64'h1000_0000_0000_0000;
   localparam longint IND_HI         = (64'sd1 <<< 40) - 1;
   localparam longint IND_LO         = -(64'sd1 <<< 40);

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [23:0] price, [24] both_ready
   logic [2:0]  req_tuser = '0;   // [1:0] command, [2] is_dependent
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // [40:0] indicator
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   ewma_pair_regression_residual u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // predictor state
   longint      decay;
   bit          is_ready;
   bit          intr_flag;
   longint      cur_dep, cur_indep, twice_init;
   longint      avg_dep, avg_indep, avg_cross, avg_sq;
   longint      last_ind;

   logic [40:0] indicator_q[$];
   int          fail_count = 0;
   bit          calm = 1'b0;

   // rounded (v * w / 2^16), magnitude rounded half away from zero
   function automatic longint weight_round(longint v, longint w);
      bit                neg;
      longint unsigned   m, p;
      neg = v < 0;
      m = neg ? -v : v;
      p = (m >> 16) * w + ((((m & 64'hFFFF) * w) + 32768) >> 16);
      return neg ? -longint'(p) : longint'(p);
   endfunction

   function automatic longint regress_residual();
      longint          dx, dy, sq, v;
      longint unsigned mc, mx, q;
      logic [127:0]    prod, quo;
      bit              neg;
      dx = cur_indep * Q16 - avg_indep;
      dy = cur_dep * Q16 - avg_dep;
      neg = (avg_cross < 0) != (dx < 0);
      mc = avg_cross < 0 ? -avg_cross : avg_cross;
      mx = dx < 0 ? -dx : dx;
      sq = avg_sq;
      prod = {64'd0, mc} * {64'd0, mx};
      quo = prod / {64'd0, sq};
      q = (quo > {64'd0, QUO_CAP}) ? QUO_CAP : quo[63:0];
      v = neg ? -longint'(q) : longint'(q);
      v = v - dy + 32768;
      v = v >>> 16;
      if (v > IND_HI) v = IND_HI;
      if (v < IND_LO) v = IND_LO;
      return v;
   endfunction

   function automatic void reseed_averages();
      avg_dep   = cur_dep * Q16;
      avg_indep = cur_indep * Q16;
      avg_cross = cur_dep * cur_indep;
      avg_sq    = cur_indep * cur_indep;
      last_ind  = 0;
   endfunction

   // advance the predictor by one accepted event; returns 1 if a word is due
   function automatic bit track_event(cmd_type cmd, bit dep, longint price, bit both,
                                      output logic [40:0] ind);
      longint w;
      ind = '0;
      case (cmd)
         CMD_INTR: begin
            if (dep) return 1'b0;
            intr_flag = 1'b1;
            last_ind = 0;
            return 1'b1;
         end
         CMD_RESUME: begin
            if (!dep) begin
               reseed_averages();
               intr_flag = 1'b0;
            end
            return 1'b0;
         end
         CMD_NONE: return 1'b0;
         default: ;
      endcase
      if (!is_ready) begin
         if (dep) cur_dep = price;
         else begin
            cur_indep = price;
            twice_init = price * 2;
         end
         if (both) begin
            is_ready = 1'b1;
            reseed_averages();
         end
      end else begin
         w = Q16 - decay;
         if (dep) cur_dep = price;
         else cur_indep = twice_init - price;
         avg_dep   += weight_round(cur_dep * Q16 - avg_dep, w);
         avg_indep += weight_round(cur_indep * Q16 - avg_indep, w);
         avg_cross += weight_round(cur_dep * cur_indep - avg_cross, w);
         avg_sq    += weight_round(cur_indep * cur_indep - avg_sq, w);
         last_ind = (avg_sq > Q16) ? regress_residual() : 0;
      end
      ind = last_ind[40:0];
      return 1'b1;
   endfunction

   // send one event word; typed-in expectation replaces the predicted one
   task automatic send_event(cmd_type cmd, bit dep, logic [23:0] price, bit both,
                             bit fixed, logic [40:0] fixed_ind);
      logic [40:0] ind;
      bit          due;
      int          gap;
      req_tvalid <= 1'b1;
      req_tuser  <= {dep, cmd};
      req_tdata  <= {7'd0, both, price};
      do @(posedge clock); while (!req_tready);
      due = track_event(cmd, dep, longint'(price), both, ind);
      if (due) indicator_q.push_back(fixed ? fixed_ind : ind);
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_and_settle();
      req_tvalid <= 1'b0;
      while (indicator_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_decay(logic [15:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      decay = value;
   endtask

   // result side: random stall bursts, none in the closing stretch
   always begin
      @(posedge clock);
      if (!calm && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      rsp_tready <= 1'b1;
   end

   // result check against the oldest pending indicator
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (indicator_q.size() == 0) begin
            $error("unexpected word: indicator actual %h", rsp_tdata[40:0]);
            fail_count++;
         end else begin
            if (rsp_tdata[40:0] !== indicator_q[0]) begin
               $error("indicator: expected %h actual %h", indicator_q[0], rsp_tdata[40:0]);
               fail_count++;
            end
            void'(indicator_q.pop_front());
         end
      end
   end

   // watchdog on cycles without any handshake
   int idle_cycles = 0;
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   typedef struct {
      cmd_type     cmd;
      bit          dep;
      logic [23:0] price;
      bit          both;
      bit          fixed;
      logic [40:0] ind;
   } event_row_type;

   event_row_type directed[24] = '{
      // not ready: latest prices stored, indicator stays 0
      '{CMD_PRICE,  1'b1, 24'hFFFFFF, 1'b0, 1'b1, 41'd0},
      '{CMD_PRICE,  1'b0, 24'h000000, 1'b0, 1'b1, 41'd0},
      '{CMD_INTR,   1'b1, 24'h000000, 1'b0, 1'b0, 41'd0},
      '{CMD_INTR,   1'b0, 24'hFFFFFF, 1'b1, 1'b1, 41'd0},
      '{CMD_NONE,   1'b0, 24'h123456, 1'b1, 1'b0, 41'd0},
      '{CMD_RESUME, 1'b1, 24'h000000, 1'b0, 1'b0, 41'd0},
      '{CMD_RESUME, 1'b0, 24'h000000, 1'b0, 1'b0, 41'd0},
      '{CMD_PRICE,  1'b1, 24'h054321, 1'b0, 1'b1, 41'd0},
      // seeding
      '{CMD_PRICE,  1'b0, 24'h020000, 1'b1, 1'b1, 41'd0},
      // tracked updates, mirrored independent side
      '{CMD_PRICE,  1'b0, 24'h01FF00, 1'b1, 1'b0, 41'd0},
      '{CMD_PRICE,  1'b1, 24'h055000, 1'b0, 1'b0, 41'd0},
      '{CMD_PRICE,  1'b0, 24'hFFFFFF, 1'b0, 1'b0, 41'd0},
      '{CMD_PRICE,  1'b1, 24'h000000, 1'b1, 1'b0, 41'd0},
      '{CMD_PRICE,  1'b0, 24'h000000, 1'b0, 1'b0, 41'd0},
      '{CMD_PRICE,  1'b0, 24'h03FFFF, 1'b0, 1'b0, 41'd0},
      '{CMD_PRICE,  1'b1, 24'hFFFFFF, 1'b0, 1'b0, 41'd0},
      '{CMD_INTR,   1'b0, 24'h000000, 1'b0, 1'b1, 41'd0},
      '{CMD_PRICE,  1'b0, 24'h020100, 1'b0, 1'b0, 41'd0},
      '{CMD_RESUME, 1'b0, 24'h000000, 1'b0, 1'b0, 41'd0},
      '{CMD_PRICE,  1'b1, 24'h050000, 1'b0, 1'b0, 41'd0},
      // independent price near twice_initial: square average at most 1.0
      '{CMD_PRICE,  1'b0, 24'h03FF80, 1'b0, 1'b0, 41'd0},
      '{CMD_RESUME, 1'b0, 24'h000000, 1'b0, 1'b0, 41'd0},
      '{CMD_PRICE,  1'b0, 24'h03FFC0, 1'b0, 1'b0, 41'd0},
      '{CMD_PRICE,  1'b1, 24'h000100, 1'b1, 1'b0, 41'd0}
   };

   initial begin : stimulus
      logic [15:0] decay_set[4];
      cmd_type     cmd;
      bit          dep;
      logic [23:0] price;
      longint      half;
      int          pick, per_phase;

      decay = DECAY_RST;
      is_ready = 1'b0;
      intr_flag = 1'b0;
      cur_dep = 0; cur_indep = 0; twice_init = 0;
      avg_dep = 0; avg_indep = 0; avg_cross = 0; avg_sq = 0;
      last_ind = 0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_event(directed[i].cmd, directed[i].dep, directed[i].price, directed[i].both,
                    directed[i].fixed, directed[i].ind);

      decay_set[0] = 16'd0;
      decay_set[1] = 16'd65535;
      decay_set[2] = 16'($urandom_range(0, 65535));
      decay_set[3] = DECAY_RST;
      per_phase = RANDOM_WORDS / 4;

      for (int ph = 0; ph < 4; ph++) begin
         drain_and_settle();
         write_decay(decay_set[ph]);
         // reseed so each setting starts from a clean average
         send_event(CMD_RESUME, 1'b0, 24'd0, 1'b0, 1'b0, '0);
         for (int n = 0; n < per_phase; n++) begin
            if (ph == 3 && n > per_phase - 80) calm = 1'b1;
            pick = $urandom_range(0, 99);
            dep = $urandom_range(0, 1);
            if (pick < 3) cmd = CMD_INTR;
            else if (pick < 6) cmd = CMD_RESUME;
            else if (pick < 8) cmd = CMD_NONE;
            else cmd = CMD_PRICE;
            half = twice_init / 2;
            case ($urandom_range(0, 4))
               0: price = 24'($urandom);
               1: price = 24'($urandom_range(0, 1023));
               2: price = 24'(half + $urandom_range(0, 512) - 256);
               3: price = 24'(half + $urandom_range(0, 65535) - 32768);
               default: price = 24'($urandom_range(24'h010000, 24'h100000));
            endcase
            send_event(cmd, dep, price, $urandom_range(0, 1), 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      while (indicator_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (indicator_q.size() != 0) fail_count++;
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
